[sv/assert_macros.svh]
// assertion macros used by the checker file isotp_seg_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is asserted
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// concurrent check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

[sv/isotp_pkg.sv]
// shared constants and the frame type for the iso-tp segmenter
// no dependencies
package isotp_pkg;

    localparam int FRAME_BYTES   = 8;
    localparam int FF_DATA_BYTES = 6;
    localparam int CF_DATA_BYTES = 7;
    localparam int PCI_SHIFT     = 4;
    localparam int LEN_BITS      = 12;
    localparam int ID_BITS       = 29;
    localparam int FILL_BITS     = $clog2(FRAME_BYTES);

    // command codes on the input tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // pci nibbles
    localparam logic [7-PCI_SHIFT:0] PCI_SF = 4'h0;
    localparam logic [7-PCI_SHIFT:0] PCI_FF = 4'h1;
    localparam logic [7-PCI_SHIFT:0] PCI_CF = 4'h2;

    // register word index
    localparam logic REG_PAD_FRAMES = 1'b0;

    localparam logic [3:0] LEN_FULL = 4'(FRAME_BYTES);

    typedef struct packed {
        logic [3:0]                  dlc;
        logic [FRAME_BYTES-1:0][7:0] data;
        logic [ID_BITS-1:0]          can_id;
        logic                        message_end;
    } frame_t;

endpackage

[sv/isotp_seg_core.sv]
// frame builder: message state, frame store and frame assembly
// depends on isotp_pkg
module isotp_seg_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            pad_frames,
    input  logic                            fire,
    input  logic                            cmd,
    input  logic [isotp_pkg::ID_BITS-1:0]   arb_id,
    input  logic [isotp_pkg::LEN_BITS-1:0]  msg_size,
    input  logic [7:0]                      data_byte,
    output logic                            emit,
    output isotp_pkg::frame_t               frame
);

    localparam logic [isotp_pkg::FILL_BITS-1:0] FILL_LAST =
        isotp_pkg::FILL_BITS'(isotp_pkg::FRAME_BYTES - 1);
    localparam logic [isotp_pkg::FILL_BITS-1:0] FILL_FF =
        isotp_pkg::FILL_BITS'(isotp_pkg::FRAME_BYTES - isotp_pkg::FF_DATA_BYTES);
    localparam logic [isotp_pkg::FILL_BITS-1:0] FILL_CF =
        isotp_pkg::FILL_BITS'(isotp_pkg::FRAME_BYTES - isotp_pkg::CF_DATA_BYTES);
    localparam logic [isotp_pkg::FILL_BITS-1:0] FILL_ONE =
        isotp_pkg::FILL_BITS'(1);
    localparam logic [isotp_pkg::LEN_BITS-1:0]  LEFT_ONE =
        isotp_pkg::LEN_BITS'(1);

    logic [isotp_pkg::ID_BITS-1:0]              id_reg, id_next;
    logic [2:0]                                 size_reg, size_next;
    logic [isotp_pkg::LEN_BITS-1:0]             left_reg, left_next, left_dec;
    logic [isotp_pkg::FRAME_BYTES-1:0][7:0]     store_reg, store_next, store_wr;
    logic [isotp_pkg::FILL_BITS-1:0]            fill_reg, fill_next;
    logic [3:0]                                 seq_reg, seq_next;
    logic                                       multi_reg, multi_next;
    logic                                       busy_reg, busy_next;

    always_comb begin
        id_next    = id_reg;
        size_next  = size_reg;
        left_next  = left_reg;
        store_next = store_reg;
        fill_next  = fill_reg;
        seq_next   = seq_reg;
        multi_next = multi_reg;
        busy_next  = busy_reg;
        emit       = 1'b0;

        store_wr           = store_reg;
        store_wr[fill_reg] = data_byte;
        left_dec           = left_reg - LEFT_ONE;

        frame.can_id       = id_reg;
        frame.data         = store_wr;
        frame.message_end  = (left_dec == '0);
        if (multi_reg || pad_frames) begin
            frame.dlc = isotp_pkg::LEN_FULL;
        end else begin
            frame.dlc = {1'b0, size_reg} + 4'd1;
        end

        if (fire) begin
            if (cmd == isotp_pkg::CMD_START) begin
                id_next    = arb_id;
                size_next  = msg_size[2:0];
                left_next  = msg_size;
                seq_next   = 4'd1;
                store_next = '0;
                busy_next  = 1'b1;
                if (msg_size < isotp_pkg::LEN_BITS'(isotp_pkg::FRAME_BYTES)) begin
                    multi_next    = 1'b0;
                    store_next[0] = {isotp_pkg::PCI_SF, 1'b0, msg_size[2:0]};
                    fill_next     = FILL_ONE;
                    if (msg_size == '0) begin
                        // empty message leaves at once as a bare single frame
                        busy_next          = 1'b0;
                        emit               = 1'b1;
                        frame.can_id       = arb_id;
                        frame.data         = '0;
                        frame.message_end  = 1'b1;
                        frame.dlc          = pad_frames ? isotp_pkg::LEN_FULL : 4'd1;
                    end
                end else begin
                    multi_next    = 1'b1;
                    store_next[0] = {isotp_pkg::PCI_FF, msg_size[11:8]};
                    store_next[1] = msg_size[7:0];
                    fill_next     = FILL_FF;
                end
            end else if (busy_reg) begin
                left_next = left_dec;
                if (fill_reg == FILL_LAST || left_dec == '0) begin
                    emit = 1'b1;
                    // first frame does not advance the sequence
                    if (multi_reg &&
                        store_wr[0][7:isotp_pkg::PCI_SHIFT] == isotp_pkg::PCI_CF) begin
                        seq_next = seq_reg + 4'd1;
                    end
                    store_next    = '0;
                    store_next[0] = {isotp_pkg::PCI_CF, seq_next};
                    fill_next     = FILL_CF;
                    if (left_dec == '0) begin
                        busy_next = 1'b0;
                    end
                end else begin
                    store_next = store_wr;
                    fill_next  = fill_reg + FILL_ONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg  <= '0;
            fill_reg  <= '0;
            seq_reg   <= 4'd1;
            multi_reg <= 1'b0;
            busy_reg  <= 1'b0;
        end else begin
            left_reg  <= left_next;
            fill_reg  <= fill_next;
            seq_reg   <= seq_next;
            multi_reg <= multi_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg    <= id_next;
        size_reg  <= size_next;
        store_reg <= store_next;
    end

endmodule

[sv/isotp_seg_skid.sv]
// two-entry output buffer: result register plus one skid entry
// depends on isotp_pkg
module isotp_seg_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  isotp_pkg::frame_t in_frame,
    output logic              out_valid,
    input  logic              out_ready,
    output isotp_pkg::frame_t out_frame
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    isotp_pkg::frame_t out_frame_reg;
    isotp_pkg::frame_t skid_frame_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_frame = out_frame_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_valid;
            end
        end else if (in_valid) begin
            // result register stalled, park the new frame
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            out_frame_reg <= skid_valid_reg ? skid_frame_reg : in_frame;
        end else if (in_valid && !skid_valid_reg) begin
            skid_frame_reg <= in_frame;
        end
    end

endmodule

[sv/isotp_frame_segmenter_unit.sv]
// iso-tp segmenter top level: stream ports, register port, core and output buffer
// depends on isotp_pkg, isotp_seg_core, isotp_seg_skid
// output: a completed frame is registered in the output buffer before it appears on m_axis
// throughput: one input transfer per cycle while s_axis_tready is high, set by the frame builder
// s_axis_tready drops only while both entries of the two-entry output buffer are full
// reset: synchronous, active low; clears message state, output buffer and pad_frames
module isotp_frame_segmenter_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,   // arb_id[28:0], msg_size[40:29], data_byte[48:41]
    input  logic         s_axis_tuser,   // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // can_id[28:0], byte0..byte7[92:29], dlc[96:93]
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic              pad_frames_reg;
    logic              fire;
    logic              emit;
    isotp_pkg::frame_t core_frame;
    isotp_pkg::frame_t out_frame;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_frames_reg <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == isotp_pkg::REG_PAD_FRAMES) begin
            pad_frames_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == isotp_pkg::REG_PAD_FRAMES) begin
            prdata[0] = pad_frames_reg;
        end
    end

    assign fire = s_axis_tvalid && s_axis_tready;

    isotp_seg_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pad_frames (pad_frames_reg),
        .fire       (fire),
        .cmd        (s_axis_tuser),
        .arb_id     (s_axis_tdata[28:0]),
        .msg_size   (s_axis_tdata[40:29]),
        .data_byte  (s_axis_tdata[48:41]),
        .emit       (emit),
        .frame      (core_frame)
    );

    isotp_seg_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (emit),
        .in_ready  (s_axis_tready),
        .in_frame  (core_frame),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_frame (out_frame)
    );

    assign m_axis_tdata = {7'b0, out_frame.dlc, out_frame.data, out_frame.can_id};
    assign m_axis_tlast = out_frame.message_end;

endmodule

[sv/isotp_seg_checker.sv]
// port-level checks for the iso-tp segmenter, bound to the top level
// depends on assert_macros.svh and isotp_frame_segmenter_unit
`include "assert_macros.svh"

module isotp_seg_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic         m_axis_tlast
);

    // a frame offered but not taken stays offered
    `ASSERT_CLK(a_out_hold, aclk, aresetn, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)

    // frame length is always between one and eight
    `ASSERT_CLK(a_len_range, aclk, aresetn,
        m_axis_tvalid |-> (m_axis_tdata[96:93] != 4'd0 && m_axis_tdata[96:93] <= 4'd8))

    // a first frame is full length and never ends the message
    `ASSERT_CLK(a_first_frame, aclk, aresetn,
        (m_axis_tvalid && m_axis_tdata[36:33] == 4'h1) |->
        (m_axis_tdata[96:93] == 4'd8 && !m_axis_tlast))

    // input back-pressure only while a result is waiting
    `ASSERT_CLK(a_ready_stall, aclk, aresetn, !s_axis_tready |-> m_axis_tvalid)

endmodule

bind isotp_frame_segmenter_unit isotp_seg_checker u_checker (.*);
